// File: rtl/core/mvv_pkg.sv
`default_nettype none
package mvv_pkg;

  // Default window depth
  localparam int unsigned DEF_WINDOW_SLOTS = 8;

  // Width of the micro-program counter
  localparam int unsigned UPC_W = 3;

  // Input item kinds
  localparam logic OPC_WRITE = 1'b0;
  localparam logic OPC_EVAL  = 1'b1;

  // Datapath operations driven by one control word
  typedef enum logic [2:0] {
    OP_NOP,
    OP_LOAD,
    OP_CMP,
    OP_PUSH,
    OP_SORT,
    OP_DECIDE,
    OP_RESP
  } op_e;

  // Sequencing conditions
  typedef enum logic [2:0] {
    C_NEXT,
    C_JUMP,
    C_DISPATCH,
    C_INNER,
    C_OUTER,
    C_OUT_FREE
  } cond_e;

  // Program step addresses
  localparam logic [UPC_W-1:0] U_IDLE   = 3'd0;
  localparam logic [UPC_W-1:0] U_LOAD   = 3'd1;
  localparam logic [UPC_W-1:0] U_CMP    = 3'd2;
  localparam logic [UPC_W-1:0] U_PUSH   = 3'd3;
  localparam logic [UPC_W-1:0] U_SORT   = 3'd4;
  localparam logic [UPC_W-1:0] U_DECIDE = 3'd5;
  localparam logic [UPC_W-1:0] U_RESP   = 3'd6;

  typedef struct packed {
    op_e              op;
    cond_e            cond;
    logic [UPC_W-1:0] target;
    logic             inner_inc;
    logic             outer_inc;
  } uword_t;

  // Control from the sequencer to the datapath
  typedef struct packed {
    op_e  op;
    logic wr_en;
    logic odd;
  } ctrl_t;

  // Control store
  function automatic uword_t ucode_rom(logic [UPC_W-1:0] addr);
    uword_t w;
    unique case (addr)
      U_IDLE:   w = '{op: OP_NOP,    cond: C_DISPATCH, target: U_RESP,
                      inner_inc: 1'b0, outer_inc: 1'b0};
      U_LOAD:   w = '{op: OP_LOAD,   cond: C_NEXT,     target: U_IDLE,
                      inner_inc: 1'b0, outer_inc: 1'b0};
      U_CMP:    w = '{op: OP_CMP,    cond: C_INNER,    target: U_CMP,
                      inner_inc: 1'b1, outer_inc: 1'b0};
      U_PUSH:   w = '{op: OP_PUSH,   cond: C_OUTER,    target: U_LOAD,
                      inner_inc: 1'b0, outer_inc: 1'b1};
      U_SORT:   w = '{op: OP_SORT,   cond: C_INNER,    target: U_SORT,
                      inner_inc: 1'b1, outer_inc: 1'b0};
      U_DECIDE: w = '{op: OP_DECIDE, cond: C_NEXT,     target: U_IDLE,
                      inner_inc: 1'b0, outer_inc: 1'b0};
      U_RESP:   w = '{op: OP_RESP,   cond: C_OUT_FREE, target: U_IDLE,
                      inner_inc: 1'b0, outer_inc: 1'b0};
      default:  w = '{op: OP_NOP,    cond: C_JUMP,     target: U_IDLE,
                      inner_inc: 1'b0, outer_inc: 1'b0};
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/mvv_sequencer.sv
`default_nettype none
module mvv_sequencer import mvv_pkg::*; #(
  parameter int unsigned WINDOW_SLOTS = DEF_WINDOW_SLOTS
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  in_valid_i,
  input  wire logic  opcode_i,
  input  wire logic  out_free_i,
  output logic       in_ready_o,
  output ctrl_t      ctrl_o
);

  localparam int unsigned IDXW = $clog2(WINDOW_SLOTS);
  localparam logic [IDXW-1:0] IDX_LAST = IDXW'(WINDOW_SLOTS - 1);

  logic [UPC_W-1:0] upc_q, upc_d;
  logic [IDXW-1:0]  inner_q, inner_d;
  logic [IDXW-1:0]  outer_q, outer_d;
  uword_t           uw;
  logic             in_fire;
  logic             inner_last;
  logic             outer_last;

  assign uw         = ucode_rom(upc_q);
  assign in_ready_o = (upc_q == U_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign inner_last = (inner_q == IDX_LAST);
  assign outer_last = (outer_q == IDX_LAST);

  // Pick the next step
  always_comb begin
    upc_d = upc_q;
    unique case (uw.cond)
      C_NEXT:     upc_d = upc_q + 1'b1;
      C_JUMP:     upc_d = uw.target;
      C_DISPATCH: begin
        if (in_fire) begin
          upc_d = (opcode_i == OPC_EVAL) ? upc_q + 1'b1 : uw.target;
        end
      end
      C_INNER:    upc_d = inner_last ? upc_q + 1'b1 : uw.target;
      C_OUTER:    upc_d = outer_last ? upc_q + 1'b1 : uw.target;
      C_OUT_FREE: upc_d = out_free_i ? uw.target : upc_q;
      default:    upc_d = U_IDLE;
    endcase
  end

  // Advance loop counters, wrapping at the last index
  always_comb begin
    inner_d = inner_q;
    outer_d = outer_q;
    if (uw.inner_inc) begin
      inner_d = inner_last ? '0 : inner_q + 1'b1;
    end
    if (uw.outer_inc) begin
      outer_d = outer_last ? '0 : outer_q + 1'b1;
    end
  end

  // Drive the datapath
  always_comb begin
    ctrl_o.op    = uw.op;
    ctrl_o.wr_en = in_fire && (opcode_i == OPC_WRITE);
    ctrl_o.odd   = inner_q[0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q   <= U_IDLE;
      inner_q <= '0;
      outer_q <= '0;
    end else begin
      upc_q   <= upc_d;
      inner_q <= inner_d;
      outer_q <= outer_d;
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/mvv_datapath.sv
`default_nettype none
module mvv_datapath import mvv_pkg::*; #(
  parameter int unsigned WINDOW_SLOTS = DEF_WINDOW_SLOTS
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire ctrl_t       ctrl_i,
  input  wire logic [2:0]  slot_i,
  input  wire logic [15:0] sample_i,
  input  wire logic [3:0]  thr_i,
  output logic [15:0]      accepted_o,
  output logic             changed_o,
  output logic [3:0]       top_count_o
);

  localparam int unsigned CNTW       = $clog2(WINDOW_SLOTS + 1);
  localparam int unsigned CMPW       = (CNTW > 4) ? CNTW : 4;
  localparam int unsigned SLOT_LIMIT = 8;

  logic [15:0]     win_q [WINDOW_SLOTS];
  logic [15:0]     win_d [WINDOW_SLOTS];
  logic [CNTW-1:0] cnt_q [WINDOW_SLOTS];
  logic [CNTW-1:0] cnt_d [WINDOW_SLOTS];
  logic [15:0]     ref_q, ref_d;
  logic [CNTW-1:0] acc_q, acc_d;
  logic [15:0]     accepted_q, accepted_d;
  logic            changed_q, changed_d;
  logic [3:0]      top_q, top_d;
  logic [CMPW-1:0] top_ext;

  assign top_ext = CMPW'(cnt_q[0]);

  always_comb begin
    win_d      = win_q;
    cnt_d      = cnt_q;
    ref_d      = ref_q;
    acc_d      = acc_q;
    accepted_d = accepted_q;
    changed_d  = changed_q;
    top_d      = top_q;

    // Store a reading; slots past the window are dropped
    for (int k = 0; k < WINDOW_SLOTS; k++) begin
      if (ctrl_i.wr_en && (k < SLOT_LIMIT) && (slot_i == 3'(k))) begin
        win_d[k] = sample_i;
      end
    end

    unique case (ctrl_i.op)
      // Latch the value under count
      OP_LOAD: begin
        ref_d = win_q[0];
        acc_d = '0;
      end
      // Count one match and rotate the window
      OP_CMP: begin
        acc_d = acc_q + CNTW'(ref_q == win_q[0]);
        for (int k = 0; k < WINDOW_SLOTS; k++) begin
          win_d[k] = win_q[(k + 1) % WINDOW_SLOTS];
        end
      end
      // Shift the finished count in, bring the next entry to the head
      OP_PUSH: begin
        for (int k = 0; k < WINDOW_SLOTS - 1; k++) begin
          cnt_d[k] = cnt_q[k + 1];
        end
        cnt_d[WINDOW_SLOTS-1] = acc_q;
        for (int k = 0; k < WINDOW_SLOTS; k++) begin
          win_d[k] = win_q[(k + 1) % WINDOW_SLOTS];
        end
      end
      // One odd-even transposition round; swap only on strictly greater
      OP_SORT: begin
        for (int k = 0; k < WINDOW_SLOTS - 1; k++) begin
          if ((((k % 2) == 1) == ctrl_i.odd) && (cnt_q[k + 1] > cnt_q[k])) begin
            cnt_d[k]     = cnt_q[k + 1];
            cnt_d[k + 1] = cnt_q[k];
            win_d[k]     = win_q[k + 1];
            win_d[k + 1] = win_q[k];
          end
        end
      end
      // Take the head value if its count meets the threshold
      OP_DECIDE: begin
        top_d = (top_ext > CMPW'(15)) ? 4'd15 : top_ext[3:0];
        if (top_ext >= CMPW'(thr_i)) begin
          accepted_d = win_q[0];
          changed_d  = (win_q[0] != accepted_q);
        end
      end
      default: ;
    endcase
  end

  // Window and vote result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < WINDOW_SLOTS; k++) begin
        win_q[k] <= '0;
      end
      accepted_q <= '0;
      changed_q  <= 1'b0;
      top_q      <= '0;
    end else begin
      win_q      <= win_d;
      accepted_q <= accepted_d;
      changed_q  <= changed_d;
      top_q      <= top_d;
    end
  end

  // Scratch registers
  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    ref_q <= ref_d;
    acc_q <= acc_d;
  end

  assign accepted_o  = accepted_q;
  assign changed_o   = changed_q;
  assign top_count_o = top_q;

endmodule
`default_nettype wire

// File: rtl/core/sample_mode_vote_validator_core.sv
// Mode vote over a window of WINDOW_SLOTS 16-bit readings. A write transfer
// (tuser = 0) stores a reading in a slot and returns the current result through
// the output register; writes to slots past the window are dropped. An
// evaluate transfer (tuser = 1) counts the occurrences of every slot's value,
// stably reorders the window by descending count, and accepts the head value
// when its count reaches agree_threshold (stored clamped to the window size).
// An evaluation of a window of N slots (8 by default) runs a serial compare
// loop, which checks every slot's value against every slot once through a
// rotating window, followed by N odd-even sort rounds. One item is in work
// at a time; a finished result waits in the output register while the next
// item is accepted. The window is cleared at reset.
`default_nettype none
module sample_mode_vote_validator_core import mvv_pkg::*; #(
  parameter int unsigned WINDOW_SLOTS = DEF_WINDOW_SLOTS
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Input stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,  // slot[2:0], sample_value[18:3], zero
  input  wire logic [0:0]  s_axis_tuser,  // opcode[0]
  // Result stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,  // validated_value[15:0],
                                          // value_changed[16], top_count[20:17]
  // Configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int unsigned CNTW = $clog2(WINDOW_SLOTS + 1);
  localparam int unsigned CMPW = (CNTW > 4) ? CNTW : 4;
  localparam logic        REG_THRESHOLD = 1'b0;
  localparam logic [3:0]  THR_RESET =
    (WINDOW_SLOTS < 8) ? 4'(WINDOW_SLOTS) : 4'd8;

  ctrl_t       ctrl;
  logic        out_free;
  logic        out_load;
  logic        out_valid_q, out_valid_d;
  logic [23:0] out_data_q;
  logic [3:0]  thr_q;
  logic [15:0] accepted;
  logic        changed;
  logic [3:0]  top_count;
  logic        cfg_wr;

  mvv_sequencer #(
    .WINDOW_SLOTS (WINDOW_SLOTS)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .opcode_i   (s_axis_tuser[0]),
    .out_free_i (out_free),
    .in_ready_o (s_axis_tready),
    .ctrl_o     (ctrl)
  );

  mvv_datapath #(
    .WINDOW_SLOTS (WINDOW_SLOTS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .slot_i      (s_axis_tdata[2:0]),
    .sample_i    (s_axis_tdata[18:3]),
    .thr_i       (thr_q),
    .accepted_o  (accepted),
    .changed_o   (changed),
    .top_count_o (top_count)
  );

  // Threshold register, clamped to the window size on write
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_THRESHOLD);
  assign prdata = (paddr[2] == REG_THRESHOLD) ? {28'd0, thr_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THR_RESET;
    end else if (cfg_wr) begin
      thr_q <= (CMPW'(pwdata[3:0]) > CMPW'(WINDOW_SLOTS)) ? 4'(WINDOW_SLOTS)
                                                          : pwdata[3:0];
    end
  end

  // Output register: load when the result step finds it free
  assign out_free    = !out_valid_q || m_axis_tready;
  assign out_load    = (ctrl.op == OP_RESP) && out_free;
  assign out_valid_d = out_load ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= {3'd0, top_count, changed, accepted};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule
`default_nettype wire
